FILE: sv/prtm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// prtm_pkg - ping round trip monitor shared definitions
// Item layouts, op codes and default sizes.
// ---------------------------------------------------------------------------
package prtm_pkg;

	localparam int SEQ_W  = 16;
	localparam int TIME_W = 32;
	localparam int CNT_W  = 32;

	localparam int PING_SLOT_COUNT_DEF = 16;
	localparam int AVERAGE_WINDOW_DEF  = 32;

	typedef enum logic [1:0] {
		OP_PING  = 2'd0,
		OP_PONG  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [TIME_W-1:0] now_us;
		logic [SEQ_W-1:0]  pong_seq;
		logic [TIME_W-1:0] pong_stamp;
	} cmd_t;

	typedef struct packed {
		logic [SEQ_W-1:0]  ping_seq;
		logic [TIME_W-1:0] ping_stamp;
		logic              pong_matched;
		logic [CNT_W-1:0]  sent_count;
		logic [CNT_W-1:0]  answered_count;
		logic [CNT_W-1:0]  lost_count;
		logic [TIME_W-1:0] rtt_last;
		logic [TIME_W-1:0] rtt_average;
		logic [TIME_W-1:0] rtt_peak;
	} rpt_t;

endpackage

FILE: sv/prtm_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// prtm_if - command and report channels
// Valid/ready channels carrying one item each.
// ---------------------------------------------------------------------------
interface prtm_cmd_if;
	import prtm_pkg::*;

	logic valid;
	logic ready;
	cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface prtm_rpt_if;
	import prtm_pkg::*;

	logic valid;
	logic ready;
	rpt_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/prtm_divider.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// prtm_divider - bit-serial restoring divider
// One quotient bit per cycle over a programmable number of leading bits.
// ---------------------------------------------------------------------------
module prtm_divider #(
	parameter int NUM_W  = 37,
	parameter int DEN_W  = 6,
	parameter int STEP_W = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [STEP_W-1:0] steps,
	output logic              busy,
	output logic              done,
	output logic [NUM_W-1:0]  quot
);

	logic [NUM_W-1:0]  num_q;
	logic [NUM_W-1:0]  quot_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;

	logic [DEN_W:0] trial;
	logic [DEN_W:0] diff;
	logic           ge;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	assign busy = busy_q;
	assign done = busy_q && (cnt_q == '0);
	assign quot = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= steps;
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q && (cnt_q != '0)) begin
			num_q  <= {num_q[NUM_W-2:0], 1'b0};
			quot_q <= {quot_q[NUM_W-2:0], ge};
			rem_q  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

endmodule

FILE: sv/prtm_slot_table.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// prtm_slot_table - outstanding ping slots
// Stamp memory with registered read, plus pending flags cleared at once.
// ---------------------------------------------------------------------------
module prtm_slot_table #(
	parameter int SLOTS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       clr,
	input  logic [$clog2(SLOTS)-1:0]   addr,
	input  logic                       rd_en,
	input  logic                       stamp_we,
	input  logic [prtm_pkg::TIME_W-1:0] wr_stamp,
	input  logic                       pend_set,
	input  logic                       pend_clr,
	output logic [prtm_pkg::TIME_W-1:0] rd_stamp,
	output logic                       rd_pend
);
	import prtm_pkg::*;

	logic [TIME_W-1:0] mem [SLOTS];
	logic [TIME_W-1:0] rd_stamp_q;
	logic [SLOTS-1:0]  pend_q;
	logic              rd_pend_q;

	assign rd_stamp = rd_stamp_q;
	assign rd_pend  = rd_pend_q;

	always_ff @(posedge clk) begin
		if (stamp_we) begin
			mem[addr] <= wr_stamp;
		end
		if (rd_en) begin
			rd_stamp_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= '0;
			rd_pend_q <= 1'b0;
		end else begin
			if (clr) begin
				pend_q <= '0;
			end else if (pend_set) begin
				pend_q[addr] <= 1'b1;
			end else if (pend_clr) begin
				pend_q[addr] <= 1'b0;
			end
			if (rd_en) begin
				rd_pend_q <= pend_q[addr];
			end
		end
	end

endmodule

FILE: sv/prtm_window.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// prtm_window - round trip moving window
// Sample memory, running sum, fill count and write pointer.
// ---------------------------------------------------------------------------
module prtm_window #(
	parameter int WIN = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        clr,
	input  logic                        rd_en,
	input  logic                        upd,
	input  logic [prtm_pkg::TIME_W-1:0] rtt,
	output logic [31+$clog2(WIN):0]     sum,
	output logic [$clog2(WIN+1)-1:0]    fill
);
	import prtm_pkg::*;

	localparam int FILL_W = $clog2(WIN + 1);
	localparam int PTR_W  = (WIN > 1) ? $clog2(WIN) : 1;
	localparam int SUM_W  = 32 + $clog2(WIN);

	logic [TIME_W-1:0] mem [WIN];
	logic [TIME_W-1:0] old_q;
	logic [PTR_W-1:0]  ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic [SUM_W-1:0]  sum_q;

	logic             full;
	logic [SUM_W-1:0] old_ext;
	logic [SUM_W-1:0] sum_nxt;

	assign full    = fill_q == FILL_W'(WIN);
	assign old_ext = full ? SUM_W'(old_q) : '0;
	assign sum_nxt = sum_q - old_ext + SUM_W'(rtt);
	assign sum     = sum_q;
	assign fill    = fill_q;

	always_ff @(posedge clk) begin
		if (upd) begin
			mem[ptr_q] <= rtt;
		end
		if (rd_en) begin
			old_q <= mem[ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			fill_q <= '0;
			sum_q  <= '0;
		end else if (clr) begin
			ptr_q  <= '0;
			fill_q <= '0;
			sum_q  <= '0;
		end else if (upd) begin
			sum_q <= sum_nxt;
			if (!full) begin
				fill_q <= fill_q + FILL_W'(1);
			end
			if (ptr_q == PTR_W'(WIN - 1)) begin
				ptr_q <= '0;
			end else begin
				ptr_q <= ptr_q + PTR_W'(1);
			end
		end
	end

endmodule

FILE: sv/ping_round_trip_monitor.sv
`timescale 1ns / 1ps
// Accept to report valid: a ping or an unmatched pong passes ST_MOD, ST_CHK and
// ST_FIN; a matched pong adds ST_WIN, ST_DST and ST_DIV, where the bit-serial
// average divide takes one step per sum bit; a clear or an unused op goes to
// ST_FIN, which waits while an earlier report is untaken. One item is in flight
// at a time and holds the input until idle; a new item is taken while the report
// waits. Reset is asynchronous: pending flags, counters and statistics clear.
// ---------------------------------------------------------------------------
// ping_round_trip_monitor - link quality monitor
// Tracks issued pings, matches pongs and keeps round trip statistics.
// ---------------------------------------------------------------------------
module ping_round_trip_monitor #(
	parameter int PING_SLOT_COUNT = prtm_pkg::PING_SLOT_COUNT_DEF,
	parameter int AVERAGE_WINDOW  = prtm_pkg::AVERAGE_WINDOW_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	prtm_cmd_if.sink   cmd,
	prtm_rpt_if.source rpt
);
	import prtm_pkg::*;

	localparam int SLOT_W     = $clog2(PING_SLOT_COUNT);
	localparam int FILL_W     = $clog2(AVERAGE_WINDOW + 1);
	localparam int SUM_W      = 32 + $clog2(AVERAGE_WINDOW);
	localparam int STEP_W     = $clog2(SUM_W + 1);
	localparam int SLOT_SHIFT = SEQ_W + SLOT_W;
	localparam int MAG_W      = SEQ_W + 1;
	localparam int PROD_W     = SEQ_W + MAG_W;
	localparam logic [MAG_W-1:0] SLOT_MAGIC =
		MAG_W'((2 ** SLOT_SHIFT + PING_SLOT_COUNT - 1) / PING_SLOT_COUNT);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_MOD  = 8'b0000_0010,
		ST_CHK  = 8'b0000_0100,
		ST_WIN  = 8'b0000_1000,
		ST_DST  = 8'b0001_0000,
		ST_DIV  = 8'b0010_0000,
		ST_FIN  = 8'b0100_0000,
		ST_HOLD = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	op_t               op_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] pstamp_q;
	logic [SEQ_W-1:0]  seq_q;
	logic [SEQ_W-1:0]  quo_q;
	logic [SLOT_W-1:0] slot_q;
	logic [TIME_W-1:0] rtt_q;
	logic [SEQ_W-1:0]  res_seq_q;
	logic [TIME_W-1:0] res_stamp_q;
	logic              match_q;

	logic [SEQ_W-1:0]  next_seq_q;
	logic [CNT_W-1:0]  sent_q;
	logic [CNT_W-1:0]  ans_q;
	logic [CNT_W-1:0]  lost_q;
	logic [TIME_W-1:0] last_q;
	logic [TIME_W-1:0] mean_q;
	logic [TIME_W-1:0] max_q;

	logic out_vld_q;
	rpt_t out_q;

	logic accept;
	logic clear_cmd;
	logic fin_go;
	logic hit;
	logic is_ping_chk;
	logic [SEQ_W-1:0]  seq_sel;
	logic [TIME_W-1:0] rtt_new;
	logic [PROD_W-1:0] slot_prod;
	logic [SEQ_W-1:0]  slot_quo;
	logic [SEQ_W-1:0]  slot_rem;

	logic              div_start;
	logic              div_busy;
	logic              div_done;
	logic [SUM_W-1:0]  div_quot;

	logic [SLOT_W-1:0] tbl_addr;
	logic [TIME_W-1:0] tbl_stamp;
	logic              tbl_pend;

	logic [SUM_W-1:0]  win_sum;
	logic [FILL_W-1:0] win_fill;

	assign cmd.ready = state_q == ST_IDLE;
	assign accept    = cmd.valid && cmd.ready;
	assign clear_cmd = accept && (cmd.data.op == OP_CLEAR);
	assign fin_go    = (state_q == ST_FIN) && (!out_vld_q || rpt.ready);

	assign is_ping_chk = (state_q == ST_CHK) && (op_q == OP_PING);
	assign hit = (state_q == ST_CHK) && (op_q == OP_PONG) && tbl_pend
		&& (tbl_stamp == pstamp_q);
	assign rtt_new = now_q - tbl_stamp;

	// slot index: sequence mod slot count by reciprocal multiply, exact for 16 bits
	assign seq_sel   = (cmd.data.op == OP_PING) ? next_seq_q : cmd.data.pong_seq;
	assign slot_prod = PROD_W'(seq_sel) * PROD_W'(SLOT_MAGIC);
	assign slot_quo  = SEQ_W'(slot_prod >> SLOT_SHIFT);
	assign slot_rem  = seq_q - quo_q * SEQ_W'(PING_SLOT_COUNT);
	assign tbl_addr  = (state_q == ST_MOD) ? slot_rem[SLOT_W-1:0] : slot_q;

	assign div_start = state_q == ST_DST;

	prtm_divider #(
		.NUM_W  (SUM_W),
		.DEN_W  (FILL_W),
		.STEP_W (STEP_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (win_sum),
		.den    (win_fill),
		.steps  (STEP_W'(SUM_W)),
		.busy   (div_busy),
		.done   (div_done),
		.quot   (div_quot)
	);

	prtm_slot_table #(
		.SLOTS (PING_SLOT_COUNT)
	) u_slots (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr      (clear_cmd),
		.addr     (tbl_addr),
		.rd_en    (state_q == ST_MOD),
		.stamp_we (is_ping_chk),
		.wr_stamp (now_q),
		.pend_set (is_ping_chk),
		.pend_clr (hit),
		.rd_stamp (tbl_stamp),
		.rd_pend  (tbl_pend)
	);

	prtm_window #(
		.WIN (AVERAGE_WINDOW)
	) u_win (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (clear_cmd),
		.rd_en  (hit),
		.upd    (state_q == ST_WIN),
		.rtt    (rtt_q),
		.sum    (win_sum),
		.fill   (win_fill)
	);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd.data.op == OP_PING || cmd.data.op == OP_PONG) begin
						state_nxt = ST_MOD;
					end else begin
						state_nxt = ST_FIN;
					end
				end
			end
			ST_MOD:  state_nxt = ST_CHK;
			ST_CHK:  state_nxt = hit ? ST_WIN : ST_FIN;
			ST_WIN:  state_nxt = ST_DST;
			ST_DST:  state_nxt = ST_DIV;
			ST_DIV: begin
				if (div_done) begin
					state_nxt = ST_FIN;
				end
			end
			ST_FIN: begin
				if (fin_go) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			out_vld_q  <= 1'b0;
			next_seq_q <= '0;
			sent_q     <= '0;
			ans_q      <= '0;
			lost_q     <= '0;
			last_q     <= '0;
			mean_q     <= '0;
			max_q      <= '0;
		end else begin
			state_q <= state_nxt;
			if (fin_go) begin
				out_vld_q <= 1'b1;
			end else if (rpt.ready) begin
				out_vld_q <= 1'b0;
			end
			if (clear_cmd) begin
				next_seq_q <= '0;
				sent_q     <= '0;
				ans_q      <= '0;
				lost_q     <= '0;
				last_q     <= '0;
				mean_q     <= '0;
				max_q      <= '0;
			end
			if (is_ping_chk) begin
				next_seq_q <= next_seq_q + SEQ_W'(1);
				sent_q     <= sent_q + CNT_W'(1);
				lost_q     <= lost_q + CNT_W'(tbl_pend);
			end
			if (hit) begin
				ans_q  <= ans_q + CNT_W'(1);
				last_q <= rtt_new;
			end
			if (state_q == ST_WIN && rtt_q > max_q) begin
				max_q <= rtt_q;
			end
			if (state_q == ST_DIV && div_done) begin
				mean_q <= div_quot[TIME_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q        <= cmd.data.op;
			now_q       <= cmd.data.now_us;
			pstamp_q    <= cmd.data.pong_stamp;
			seq_q       <= seq_sel;
			quo_q       <= slot_quo;
			res_seq_q   <= '0;
			res_stamp_q <= '0;
			match_q     <= 1'b0;
		end
		if (state_q == ST_MOD) begin
			slot_q <= slot_rem[SLOT_W-1:0];
		end
		if (is_ping_chk) begin
			res_seq_q   <= next_seq_q;
			res_stamp_q <= now_q;
		end
		if (hit) begin
			match_q <= 1'b1;
			rtt_q   <= rtt_new;
		end
		if (fin_go) begin
			out_q.ping_seq       <= res_seq_q;
			out_q.ping_stamp     <= res_stamp_q;
			out_q.pong_matched   <= match_q;
			out_q.sent_count     <= sent_q;
			out_q.answered_count <= ans_q;
			out_q.lost_count     <= lost_q;
			out_q.rtt_last       <= last_q;
			out_q.rtt_average    <= mean_q;
			out_q.rtt_peak       <= max_q;
		end
	end

	assign rpt.valid = out_vld_q;
	assign rpt.data  = out_q;

	a_idle_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !div_busy)
		else $error("divider busy while accepting");

	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		clear_cmd |=> (sent_q == '0) && (win_fill == '0) && (max_q == '0))
		else $error("clear left statistics behind");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		win_fill <= FILL_W'(AVERAGE_WINDOW))
		else $error("window fill overrun");

	a_mean_le_peak: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> (mean_q <= max_q))
		else $error("average above peak");

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb - ping round trip monitor testbench
// A table of directed commands comes first, then random ping and pong
// traffic with clears, closing on a stretch with no idling. An in-bench model
// of the slots, counters and round trip window predicts each report, and every
// report is compared field by field in order. Random stalls hit both channels.
// ---------------------------------------------------------------------------
module tb;
	import prtm_pkg::*;

	localparam int SLOTS        = PING_SLOT_COUNT_DEF;
	localparam int WIN          = AVERAGE_WINDOW_DEF;
	localparam int RANDOM_ITEMS = 832;
	localparam int N_DIR        = 18;
	localparam int LIMIT_CYCLES = 12_000_000;

	typedef struct {
		cmd_t c;
		bit   fixed;
		rpt_t r;
	} row_t;

	// report fields: seq, stamp, matched, sent, answered, lost, last, average, peak
	row_t dir_rows [N_DIR] = '{
		'{'{OP_PONG, 32'h0, 16'h0, 32'h0}, 1'b1, '0},
		'{'{OP_NONE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF}, 1'b1, '0},
		'{'{OP_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF}, 1'b1, '0},
		'{'{OP_PING, 32'hFFFF_FFFF, 16'h0, 32'h0}, 1'b1,
			'{16'd0, 32'hFFFF_FFFF, 1'b0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}},
		'{'{OP_PONG, 32'd9, 16'h0, 32'hFFFF_FFFF}, 1'b1,
			'{16'd0, 32'd0, 1'b1, 32'd1, 32'd1, 32'd0, 32'd10, 32'd10, 32'd10}},
		'{'{OP_PING, 32'h0, 16'h0, 32'h0}, 1'b1,
			'{16'd1, 32'd0, 1'b0, 32'd2, 32'd1, 32'd0, 32'd10, 32'd10, 32'd10}},
		'{'{OP_PONG, 32'd5, 16'h1, 32'h1}, 1'b1,
			'{16'd0, 32'd0, 1'b0, 32'd2, 32'd1, 32'd0, 32'd10, 32'd10, 32'd10}},
		'{'{OP_PONG, 32'hFFFF_FFFF, 16'h0011, 32'h0}, 1'b1,
			'{16'd0, 32'd0, 1'b1, 32'd2, 32'd2, 32'd0,
				32'hFFFF_FFFF, 32'h8000_0004, 32'hFFFF_FFFF}},
		'{'{OP_PONG, 32'hFFFF_FFFF, 16'h0011, 32'h0}, 1'b1,
			'{16'd0, 32'd0, 1'b0, 32'd2, 32'd2, 32'd0,
				32'hFFFF_FFFF, 32'h8000_0004, 32'hFFFF_FFFF}},
		'{'{OP_NONE, 32'd1234, 16'hFFFF, 32'hFFFF_FFFF}, 1'b1,
			'{16'd0, 32'd0, 1'b0, 32'd2, 32'd2, 32'd0,
				32'hFFFF_FFFF, 32'h8000_0004, 32'hFFFF_FFFF}},
		'{'{OP_PING, 32'd100, 16'h0, 32'h0}, 1'b0, '0},
		'{'{OP_PING, 32'd200, 16'h0, 32'h0}, 1'b0, '0},
		'{'{OP_PONG, 32'd150, 16'hFFF2, 32'd100}, 1'b0, '0},
		'{'{OP_PONG, 32'd200, 16'hFFF3, 32'd200}, 1'b0, '0},
		'{'{OP_CLEAR, 32'h0, 16'h0, 32'h0}, 1'b1, '0},
		'{'{OP_PING, 32'd12345, 16'h0, 32'h0}, 1'b1,
			'{16'd0, 32'd12345, 1'b0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}},
		'{'{OP_PONG, 32'd12352, 16'hFFF0, 32'd12345}, 1'b0, '0},
		'{'{OP_NONE, 32'h0, 16'h5A5A, 32'hA5A5_A5A5}, 1'b0, '0}
	};

	bit   clk;
	logic arst_n;

	prtm_cmd_if cmd_ch ();
	prtm_rpt_if rpt_ch ();

	ping_round_trip_monitor u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rpt    (rpt_ch)
	);

	// predicted monitor state
	logic [TIME_W-1:0] slot_time [SLOTS];
	bit                slot_live [SLOTS];
	logic [SEQ_W-1:0]  seq_next;
	logic [TIME_W-1:0] rtt_hist [WIN];
	logic [36:0]       hist_sum;
	logic [5:0]        hist_fill;
	logic [4:0]        hist_ptr;
	rpt_t              tally;

	rpt_t        expected_reports [$];
	bit          idle_on;
	int          errors;
	int          items_sent;
	int          reports_checked;
	int          matched_seen;
	int          lost_events;
	int          clears_sent;
	int unsigned cycles;

	initial forever #2 clk = ~clk;

	function automatic void forget_all();
		slot_live = '{default: 1'b0};
		slot_time = '{default: '0};
		seq_next  = '0;
		hist_sum  = '0;
		hist_fill = '0;
		hist_ptr  = '0;
		tally     = '0;
	endfunction

	function automatic rpt_t monitor_predict(input cmd_t c);
		rpt_t              r;
		int                s;
		logic [TIME_W-1:0] rtt;
		r = '0;
		case (c.op)
			OP_PING: begin
				s = seq_next % SLOTS;
				if (slot_live[s]) begin
					tally.lost_count += 1;
					lost_events++;
				end
				slot_live[s] = 1'b1;
				slot_time[s] = c.now_us;
				tally.sent_count += 1;
				r.ping_seq   = seq_next;
				r.ping_stamp = c.now_us;
				seq_next = seq_next + SEQ_W'(1);
			end
			OP_PONG: begin
				s = c.pong_seq % SLOTS;
				if (slot_live[s] && slot_time[s] == c.pong_stamp) begin
					slot_live[s] = 1'b0;
					tally.answered_count += 1;
					rtt = c.now_us - slot_time[s];
					tally.rtt_last = rtt;
					if (rtt > tally.rtt_peak)
						tally.rtt_peak = rtt;
					if (hist_fill >= WIN)
						hist_sum -= rtt_hist[hist_ptr];
					else
						hist_fill = hist_fill + 6'd1;
					rtt_hist[hist_ptr] = rtt;
					hist_sum += rtt;
					hist_ptr = 5'((hist_ptr + 1) % WIN);
					tally.rtt_average = 32'(hist_sum / hist_fill);
					r.pong_matched = 1'b1;
				end
			end
			OP_CLEAR: begin
				forget_all();
				clears_sent++;
			end
			default: ;
		endcase
		r.sent_count     = tally.sent_count;
		r.answered_count = tally.answered_count;
		r.lost_count     = tally.lost_count;
		r.rtt_last       = tally.rtt_last;
		r.rtt_average    = tally.rtt_average;
		r.rtt_peak       = tally.rtt_peak;
		return r;
	endfunction

	task automatic send_item(input cmd_t c, input bit fixed, input rpt_t typed);
		rpt_t want;
		int   gap;
		gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		if (gap > 0) begin
			@(negedge clk) cmd_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		cmd_ch.valid <= 1'b1;
		cmd_ch.data  <= c;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		want = monitor_predict(c);
		expected_reports.push_back(fixed ? typed : want);
		items_sent++;
	endtask

	task automatic drain_reports();
		@(negedge clk) cmd_ch.valid <= 1'b0;
		while (expected_reports.size() != 0) @(posedge clk);
	endtask

	function automatic void check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t mismatch %s: expected %h, actual %h", $time, what, want, got);
			errors++;
		end
	endfunction

	// report checker
	always @(posedge clk) begin : report_check
		rpt_t want;
		if (arst_n === 1'b1 && rpt_ch.valid === 1'b1 && rpt_ch.ready === 1'b1) begin
			if (expected_reports.size() == 0) begin
				$display("%0t unexpected report: expected none, actual %h", $time,
					rpt_ch.data);
				errors++;
			end else begin
				want = expected_reports.pop_front();
				check_field("ping_seq", 32'(want.ping_seq), 32'(rpt_ch.data.ping_seq));
				check_field("ping_stamp", want.ping_stamp, rpt_ch.data.ping_stamp);
				check_field("pong_matched", 32'(want.pong_matched),
					32'(rpt_ch.data.pong_matched));
				check_field("sent_count", want.sent_count, rpt_ch.data.sent_count);
				check_field("answered_count", want.answered_count,
					rpt_ch.data.answered_count);
				check_field("lost_count", want.lost_count, rpt_ch.data.lost_count);
				check_field("rtt_last", want.rtt_last, rpt_ch.data.rtt_last);
				check_field("rtt_average", want.rtt_average, rpt_ch.data.rtt_average);
				check_field("rtt_peak", want.rtt_peak, rpt_ch.data.rtt_peak);
				if (want.pong_matched)
					matched_seen++;
				reports_checked++;
			end
		end
	end

	// report side stalls
	initial begin
		int stall_left;
		stall_left   = 0;
		rpt_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				rpt_ch.ready <= 1'b0;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				rpt_ch.ready <= 1'b0;
				stall_left = $urandom_range(0, 2);
			end else begin
				rpt_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		while (cycles < LIMIT_CYCLES) @(posedge clk) cycles++;
		$display("%0t timeout with %0d reports outstanding", $time,
			expected_reports.size());
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		cmd_t              c;
		int                kind;
		int                pick;
		int                live [$];
		logic [TIME_W-1:0] clock_us;
		cmd_ch.valid = 1'b0;
		cmd_ch.data  = '0;
		arst_n       = 1'b0;
		idle_on      = 1'b1;
		clock_us     = $urandom();
		forget_all();
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_DIR; i++)
			send_item(dir_rows[i].c, dir_rows[i].fixed, dir_rows[i].r);
		drain_reports();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i >= RANDOM_ITEMS - 100)
				idle_on = 1'b0;
			else if (i % 100 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			if (i == RANDOM_ITEMS / 2)
				drain_reports();
			if ($urandom_range(0, 9) == 0)
				clock_us = $urandom();
			else
				clock_us += $urandom_range(0, 3000);
			c.now_us     = clock_us;
			c.pong_seq   = 16'($urandom());
			c.pong_stamp = $urandom();
			live.delete();
			foreach (slot_live[k])
				if (slot_live[k])
					live.push_back(k);
			kind = $urandom_range(0, 999);
			if (kind < 7) begin
				c.op = OP_CLEAR;
			end else if (kind < 40) begin
				c.op = OP_NONE;
			end else if (kind < 100) begin
				c.op = OP_PONG;
			end else if (kind < 520 || live.size() == 0) begin
				c.op = OP_PING;
			end else begin
				c.op = OP_PONG;
				pick = live[$urandom_range(0, live.size() - 1)];
				c.pong_seq   = 16'(($urandom_range(0, 65535) / SLOTS) * SLOTS + pick);
				c.pong_stamp = slot_time[pick];
				if (kind < 560)
					c.pong_stamp ^= 32'd1 << $urandom_range(0, 31);
			end
			send_item(c, 1'b0, '0);
		end

		drain_reports();
		repeat (100) @(posedge clk);
		$display("drove %0d commands (directed table plus random mix), %0d reports checked",
			items_sent, reports_checked);
		$display("saw %0d matched pongs, %0d lost pings, %0d clears, %0d errors",
			matched_seen, lost_events, clears_sent, errors);
		if (errors == 0 && expected_reports.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
